[rtl/dltq_pkg.sv]
`default_nettype none

package dltq_pkg;

   localparam int DLTQ_TIMER_SLOTS = 16;
   localparam int DLTQ_HANDLES     = 16;

   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_DEL  = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EXPIRED   = 3'd1;
   localparam logic [2:0] ST_NONE      = 3'd2;
   localparam logic [2:0] ST_ZERO      = 3'd3;
   localparam logic [2:0] ST_ARMED     = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;
   localparam logic [2:0] ST_NOT_ARMED = 3'd6;

   // read address select
   localparam logic [1:0] RD_IDX  = 2'd0;
   localparam logic [1:0] RD_IDX1 = 2'd1;
   localparam logic [1:0] RD_JM1  = 2'd2;

   // write data select; WR_SHIFT also picks the write address
   localparam logic [2:0] WR_SHRINK = 3'd0;
   localparam logic [2:0] WR_SHIFT  = 3'd1;
   localparam logic [2:0] WR_INSERT = 3'd2;
   localparam logic [2:0] WR_MERGE  = 3'd3;
   localparam logic [2:0] WR_DOWN   = 3'd4;
   localparam logic [2:0] WR_DEC    = 3'd5;

   typedef struct packed {
      logic [1:0]  op;
      logic [3:0]  timer_id;
      logic [12:0] owner_id;
      logic [31:0] delay;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  timer_out;
      logic [12:0] owner_out;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic       latch_req;
      logic       idx_clr;
      logic       idx_inc;
      logic       j_load;
      logic       j_dec;
      logic       rem_sub;
      logic       rem_load_rd;
      logic       pend_load_rd;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic [2:0] wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       arm_set;
      logic       arm_clr;
      logic       own_write;
      logic       out_load;
      logic [2:0] out_status;
      logic       out_last;
   } dltq_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       delay_zero;
      logic       armed_hit;
      logic       cnt_zero;
      logic       cnt_one;
      logic       cnt_full;
      logic       has_next;
      logic       at_end;
      logic       more;
      logic       less;
      logic       sh_done;
      logic       match;
      logic       dz;
      logic       d_one;
      logic       out_free;
   } dltq_stat_type;

endpackage

`default_nettype wire

[rtl/delta_list_timer_queue_unit.sv]
// Delta-list timer queue.
// req channel: one word per operation (add, delete, tick), valid/stall handshake;
// a word is taken when req_valid is high and req_stall low. One operation is
// in flight at a time; req_stall is high from the cycle after a word is taken
// until its last result has been loaded into the output register.
// rsp channel: add and delete give one word; a tick gives one word per expired
// timer (last set on the final one) or one "none expired" word.
// The list sits in a RAM with registered read, so every entry visited takes a
// read state and an evaluate or write state. An add compares entries from the
// head, then moves the later ones up; a flagged add goes straight to its result.
// A delete visits every entry in the list; a delete of a timer not armed goes
// straight to its result, as does a tick on an empty list. Otherwise a tick reads
// the head; each expiry moves the remaining entries down and rereads the head.
// The output register lets the next word be taken while a result waits; while
// rsp_stall is high, a pending result holds and further results wait.
// Reset empties the list at once (count and armed flags cleared); no sweep.
`default_nettype none

module delta_list_timer_queue_unit #(
   parameter int TIMER_SLOTS = dltq_pkg::DLTQ_TIMER_SLOTS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire dltq_pkg::req_word_type req_word,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output dltq_pkg::rsp_word_type      rsp_word
);
   import dltq_pkg::*;

   dltq_cmd_type  cmd;
   dltq_stat_type stat;

   dltq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   dltq_datapath #(
      .TIMER_SLOTS (TIMER_SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire

[rtl/dltq_datapath.sv]
`default_nettype none

module dltq_datapath #(
   parameter int TIMER_SLOTS = dltq_pkg::DLTQ_TIMER_SLOTS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dltq_pkg::req_word_type req_word,
   input  wire dltq_pkg::dltq_cmd_type cmd,
   output dltq_pkg::dltq_stat_type     stat,
   output logic                        rsp_valid,
   input  wire logic                  rsp_stall,
   output dltq_pkg::rsp_word_type      rsp_word
);
   import dltq_pkg::*;

   localparam int CW = $clog2(TIMER_SLOTS + 1);
   localparam int AW = $clog2(TIMER_SLOTS);

   typedef struct packed {
      logic [31:0] delta;
      logic [3:0]  timer;
   } slot_type;

   slot_type      slot_mem [TIMER_SLOTS];
   slot_type      rd_ff;
   slot_type      wr_data;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] jm1;
   logic [CW:0]   idx_p1, idx_p2, count_x;
   logic [31:0]   rem_ff, rem_in;
   logic [3:0]    pend_ff, pend_in;
   logic [12:0]   owner_ff;
   logic [1:0]    op_ff;
   logic [15:0]   armed_ff, armed_in;
   logic [15:0]   pend_bit;
   logic [12:0]   owner_tbl [DLTQ_HANDLES];

   logic          rsp_valid_ff, rsp_valid_in;
   rsp_word_type  rsp_ff, rsp_in;

   assign jm1     = j_ff - CW'(1);
   assign idx_p1  = {1'b0, idx_ff} + (CW + 1)'(1);
   assign idx_p2  = {1'b0, idx_ff} + (CW + 1)'(2);
   assign count_x = {1'b0, count_ff};
   assign pend_bit = 16'(1) << pend_ff;

   always_comb begin
      stat.op         = op_ff;
      stat.delay_zero = (rem_ff == 32'd0);
      stat.armed_hit  = armed_ff[pend_ff];
      stat.cnt_zero   = (count_ff == '0);
      stat.cnt_one    = (count_ff == CW'(1));
      stat.cnt_full   = (count_ff == CW'(TIMER_SLOTS));
      stat.has_next   = (idx_p1 < count_x);
      stat.at_end     = (idx_p1 == count_x);
      stat.more       = (idx_p2 < count_x);
      stat.less       = (rem_ff < rd_ff.delta);
      stat.sh_done    = (jm1 == idx_ff);
      stat.match      = (rd_ff.timer == pend_ff);
      stat.dz         = (rd_ff.delta == 32'd0);
      stat.d_one      = (rd_ff.delta == 32'd1);
      stat.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_IDX:  rd_addr = idx_ff[AW-1:0];
         RD_IDX1: rd_addr = idx_p1[AW-1:0];
         RD_JM1:  rd_addr = jm1[AW-1:0];
         default: rd_addr = idx_ff[AW-1:0];
      endcase
   end

   always_comb begin
      wr_addr = idx_ff[AW-1:0];
      case (cmd.wr_sel)
         WR_SHRINK: wr_data = '{delta: rd_ff.delta - rem_ff, timer: rd_ff.timer};
         WR_SHIFT: begin
            wr_data = rd_ff;
            wr_addr = j_ff[AW-1:0];
         end
         WR_INSERT: wr_data = '{delta: rem_ff, timer: pend_ff};
         WR_MERGE:  wr_data = '{delta: rd_ff.delta + rem_ff, timer: rd_ff.timer};
         WR_DOWN:   wr_data = rd_ff;
         WR_DEC:    wr_data = '{delta: rd_ff.delta - 32'd1, timer: rd_ff.timer};
         default:   wr_data = rd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_ff <= slot_mem[rd_addr];
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_p1[CW-1:0];
      end

      j_in = j_ff;
      if (cmd.j_load) begin
         j_in = count_ff;
      end else if (cmd.j_dec) begin
         j_in = jm1;
      end

      rem_in = rem_ff;
      if (cmd.latch_req) begin
         rem_in = req_word.delay;
      end else if (cmd.rem_sub) begin
         rem_in = rem_ff - rd_ff.delta;
      end else if (cmd.rem_load_rd) begin
         rem_in = rd_ff.delta;
      end

      pend_in = pend_ff;
      if (cmd.latch_req) begin
         pend_in = req_word.timer_id;
      end else if (cmd.pend_load_rd) begin
         pend_in = rd_ff.timer;
      end

      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end

      armed_in = armed_ff;
      if (cmd.arm_set) begin
         armed_in = armed_ff | pend_bit;
      end else if (cmd.arm_clr) begin
         armed_in = armed_ff & ~pend_bit;
      end
   end

   always_comb begin
      rsp_in.status    = cmd.out_status;
      rsp_in.timer_out = (cmd.out_status == ST_NONE) ? 4'd0 : pend_ff;
      rsp_in.owner_out = (cmd.out_status == ST_EXPIRED) ? owner_tbl[pend_ff] : 13'd0;
      rsp_in.last      = cmd.out_last;

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         armed_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      j_ff    <= j_in;
      rem_ff  <= rem_in;
      pend_ff <= pend_in;
      if (cmd.latch_req) begin
         op_ff    <= req_word.op;
         owner_ff <= req_word.owner_id;
      end
      if (cmd.own_write) begin
         owner_tbl[pend_ff] <= owner_ff;
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire

[rtl/dltq_ctrl.sv]
`default_nettype none

module dltq_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire dltq_pkg::dltq_stat_type stat,
   output dltq_pkg::dltq_cmd_type       cmd
);
   import dltq_pkg::*;

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DECODE  = 5'd1;
   localparam logic [4:0] S_EMIT    = 5'd2;
   localparam logic [4:0] S_ADD_RD  = 5'd3;
   localparam logic [4:0] S_ADD_EV  = 5'd4;
   localparam logic [4:0] S_SH_RD   = 5'd5;
   localparam logic [4:0] S_SH_WR   = 5'd6;
   localparam logic [4:0] S_INS     = 5'd7;
   localparam logic [4:0] S_DEL_RD  = 5'd8;
   localparam logic [4:0] S_DEL_EV  = 5'd9;
   localparam logic [4:0] S_DEL_NRD = 5'd10;
   localparam logic [4:0] S_DEL_NWR = 5'd11;
   localparam logic [4:0] S_DEL_NF  = 5'd12;
   localparam logic [4:0] S_RM_RD   = 5'd13;
   localparam logic [4:0] S_RM_WR   = 5'd14;
   localparam logic [4:0] S_RM_FIN  = 5'd15;
   localparam logic [4:0] S_TK_RD   = 5'd16;
   localparam logic [4:0] S_TK_EV   = 5'd17;
   localparam logic [4:0] S_TK2_RD  = 5'd18;
   localparam logic [4:0] S_TK2_EV  = 5'd19;

   logic [4:0] state_ff, state_in;
   logic [2:0] st_ff, st_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      st_in    = st_ff;
      cmd      = '0;
      cmd.rd_sel = RD_IDX;

      case (state_ff)
         S_IDLE: begin
            cmd.latch_req = req_valid;
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            cmd.idx_clr = 1'b1;
            case (stat.op)
               OP_ADD: begin
                  if (stat.delay_zero) begin
                     st_in    = ST_ZERO;
                     state_in = S_EMIT;
                  end else if (stat.armed_hit) begin
                     st_in    = ST_ARMED;
                     state_in = S_EMIT;
                  end else if (stat.cnt_full) begin
                     st_in    = ST_FULL;
                     state_in = S_EMIT;
                  end else if (stat.cnt_zero) begin
                     state_in = S_INS;
                  end else begin
                     state_in = S_ADD_RD;
                  end
               end
               OP_DEL: begin
                  if (!stat.armed_hit) begin
                     st_in    = ST_NOT_ARMED;
                     state_in = S_EMIT;
                  end else if (stat.cnt_zero) begin
                     state_in = S_DEL_NF;
                  end else begin
                     state_in = S_DEL_RD;
                  end
               end
               OP_TICK: begin
                  if (stat.cnt_zero) begin
                     st_in    = ST_NONE;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_TK_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end

         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = st_ff;
               cmd.out_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end

         S_ADD_RD: state_in = S_ADD_EV;

         S_ADD_EV: begin
            if (stat.less) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_SHRINK;
               cmd.j_load = 1'b1;
               state_in   = S_SH_RD;
            end else begin
               cmd.rem_sub = 1'b1;
               cmd.idx_inc = 1'b1;
               state_in    = stat.at_end ? S_INS : S_ADD_RD;
            end
         end

         S_SH_RD: begin
            cmd.rd_sel = RD_JM1;
            state_in   = S_SH_WR;
         end

         S_SH_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = WR_SHIFT;
            cmd.j_dec  = 1'b1;
            state_in   = stat.sh_done ? S_INS : S_SH_RD;
         end

         S_INS: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = WR_INSERT;
            cmd.cnt_inc   = 1'b1;
            cmd.arm_set   = 1'b1;
            cmd.own_write = 1'b1;
            st_in         = ST_OK;
            state_in      = S_EMIT;
         end

         S_DEL_RD: state_in = S_DEL_EV;

         S_DEL_EV: begin
            if (stat.match) begin
               if (stat.has_next) begin
                  cmd.rem_load_rd = 1'b1;
                  state_in        = S_DEL_NRD;
               end else begin
                  state_in = S_RM_FIN;
               end
            end else if (stat.has_next) begin
               cmd.idx_inc = 1'b1;
               state_in    = S_DEL_RD;
            end else begin
               state_in = S_DEL_NF;
            end
         end

         S_DEL_NRD: begin
            cmd.rd_sel = RD_IDX1;
            state_in   = S_DEL_NWR;
         end

         S_DEL_NWR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_MERGE;
            cmd.idx_inc = 1'b1;
            state_in    = stat.more ? S_RM_RD : S_RM_FIN;
         end

         S_DEL_NF: begin
            cmd.arm_clr = 1'b1;
            st_in       = ST_OK;
            state_in    = S_EMIT;
         end

         S_RM_RD: begin
            cmd.rd_sel = RD_IDX1;
            state_in   = S_RM_WR;
         end

         S_RM_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_DOWN;
            cmd.idx_inc = 1'b1;
            state_in    = stat.more ? S_RM_RD : S_RM_FIN;
         end

         S_RM_FIN: begin
            cmd.cnt_dec = 1'b1;
            cmd.arm_clr = 1'b1;
            cmd.idx_clr = 1'b1;
            if (stat.op == OP_DEL) begin
               st_in    = ST_OK;
               state_in = S_EMIT;
            end else if (stat.cnt_one) begin
               st_in    = ST_EXPIRED;
               state_in = S_EMIT;
            end else begin
               state_in = S_TK2_RD;
            end
         end

         S_TK_RD: state_in = S_TK_EV;

         S_TK_EV: begin
            if (!stat.dz) begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = WR_DEC;
            end
            if (stat.dz || stat.d_one) begin
               cmd.pend_load_rd = 1'b1;
               state_in         = stat.has_next ? S_RM_RD : S_RM_FIN;
            end else begin
               st_in    = ST_NONE;
               state_in = S_EMIT;
            end
         end

         S_TK2_RD: state_in = S_TK2_EV;

         // previous expiry goes out once the next head is known
         S_TK2_EV: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = ST_EXPIRED;
               cmd.out_last   = !stat.dz;
               if (stat.dz) begin
                  cmd.pend_load_rd = 1'b1;
                  state_in         = stat.has_next ? S_RM_RD : S_RM_FIN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         st_ff    <= ST_OK;
      end else begin
         state_ff <= state_in;
         st_ff    <= st_in;
      end
   end

endmodule

`default_nettype wire

[rtl/dltq_checker.sv]
`default_nettype none

module dltq_assert_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_stall,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_stall,
   input wire dltq_pkg::rsp_word_type rsp_word
);
   import dltq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second req word taken while busy");

   a_owner_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != ST_EXPIRED) |-> (rsp_word.owner_out == 13'd0))
      else $error("owner set on non-expiry word");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.status != ST_EXPIRED) |-> rsp_word.last)
      else $error("non-expiry word not last");

endmodule

bind delta_list_timer_queue_unit dltq_assert_checker u_dltq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

`default_nettype wire

[bench/dltq_checker.sv]
`default_nettype none

module dltq_checker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire dltq_pkg::req_word_type req_word,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire dltq_pkg::rsp_word_type rsp_word,
   output int                          owed_count,
   output int                          fail_count
);

   import dltq_pkg::*;

   localparam int SLOTS = DLTQ_TIMER_SLOTS;

   logic [31:0]  list_delta [SLOTS];
   logic [3:0]   list_timer [SLOTS];
   logic [12:0]  owner_by_handle [DLTQ_HANDLES];
   logic [15:0]  armed = '0;
   int           entries = 0;
   rsp_word_type rsp_owed [$];

   function automatic void owe(input logic [2:0] st, input logic [3:0] tmr,
                              input logic [12:0] own, input logic lst);
      rsp_word_type w;
      w.status    = st;
      w.timer_out = tmr;
      w.owner_out = own;
      w.last      = lst;
      rsp_owed.push_back(w);
   endfunction

   function automatic void drop_entry(input int pos);
      int i;
      for (i = pos; i + 1 < entries; i++) begin
         list_delta[i] = list_delta[i + 1];
         list_timer[i] = list_timer[i + 1];
      end
      entries--;
   endfunction

   task automatic run_timer_op(input req_word_type w);
      logic [15:0]  hbit;
      logic [31:0]  left;
      logic [3:0]   t;
      int           pos;
      int           n;
      int           k;
      rsp_word_type tail;
      hbit = 16'd1 << w.timer_id;
      case (w.op)
         OP_ADD: begin
            if (w.delay == '0) begin
               owe(ST_ZERO, w.timer_id, '0, 1'b1);
            end else if ((armed & hbit) != '0) begin
               owe(ST_ARMED, w.timer_id, '0, 1'b1);
            end else if (entries >= SLOTS) begin
               owe(ST_FULL, w.timer_id, '0, 1'b1);
            end else begin
               left = w.delay;
               pos = 0;
               while (pos < entries && left >= list_delta[pos]) begin
                  left = left - list_delta[pos];
                  pos++;
               end
               if (pos < entries) list_delta[pos] = list_delta[pos] - left;
               for (n = entries; n > pos; n--) begin
                  list_delta[n] = list_delta[n - 1];
                  list_timer[n] = list_timer[n - 1];
               end
               list_delta[pos] = left;
               list_timer[pos] = w.timer_id;
               entries++;
               owner_by_handle[w.timer_id] = w.owner_id;
               armed = armed | hbit;
               owe(ST_OK, w.timer_id, '0, 1'b1);
            end
         end
         OP_DEL: begin
            if ((armed & hbit) == '0) begin
               owe(ST_NOT_ARMED, w.timer_id, '0, 1'b1);
            end else begin
               pos = 0;
               while (pos < entries && list_timer[pos] != w.timer_id) pos++;
               if (pos < entries) begin
                  if (pos + 1 < entries) list_delta[pos + 1] = list_delta[pos + 1] + list_delta[pos];
                  drop_entry(pos);
               end
               armed = armed & ~hbit;
               owe(ST_OK, w.timer_id, '0, 1'b1);
            end
         end
         OP_TICK: begin
            k = 0;
            if (entries > 0 && list_delta[0] != '0) list_delta[0] = list_delta[0] - 32'd1;
            while (entries > 0 && list_delta[0] == '0 && k < DLTQ_HANDLES) begin
               t = list_timer[0];
               drop_entry(0);
               armed = armed & ~(16'd1 << t);
               owe(ST_EXPIRED, t, owner_by_handle[t], 1'b0);
               k++;
            end
            if (k == 0) begin
               owe(ST_NONE, '0, '0, 1'b1);
            end else begin
               tail = rsp_owed.pop_back();
               tail.last = 1'b1;
               rsp_owed.push_back(tail);
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      int           bad;
      bad = 0;
      if (reset) begin
         armed = '0;
         entries = 0;
         rsp_owed.delete();
      end else begin
         if (req_valid && !req_stall) run_timer_op(req_word);
         if (rsp_valid && !rsp_stall) begin
            if (rsp_owed.size() == 0) begin
               $error("unexpected word: status %0d timer_out %0d owner_out %0d last %0d",
                      rsp_word.status, rsp_word.timer_out, rsp_word.owner_out, rsp_word.last);
               bad = 1;
            end else begin
               want = rsp_owed.pop_front();
               if (rsp_word.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_word.status);
                  bad = 1;
               end
               if (rsp_word.timer_out !== want.timer_out) begin
                  $error("timer_out: expected %0d, got %0d", want.timer_out, rsp_word.timer_out);
                  bad = 1;
               end
               if (rsp_word.owner_out !== want.owner_out) begin
                  $error("owner_out: expected %0d, got %0d", want.owner_out, rsp_word.owner_out);
                  bad = 1;
               end
               if (rsp_word.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_word.last);
                  bad = 1;
               end
            end
         end
      end
      fail_count <= fail_count + bad;
      owed_count <= rsp_owed.size();
   end

endmodule

`default_nettype wire

[bench/tb_top.sv]
`default_nettype none

module tb_top;

   import dltq_pkg::*;

   localparam int         QUIET_LIMIT = 3000;
   localparam int         PHASE_WORDS = 22;
   localparam int         HOLD_CYCLES = 300;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   int           owed_count;
   int           fail_count;
   int           idle_pct = 0;
   int           stall_pct = 0;
   logic         hold_go = 1'b0;
   logic         hold_used = 1'b0;
   int           hold_left = 0;
   int           quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   delta_list_timer_queue_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   dltq_checker list_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .owed_count (owed_count),
      .fail_count (fail_count)
   );

   // receiver: one long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_used) begin
         rsp_stall <= 1'b1;
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic req_word_type timer_req(input logic [1:0] op, input logic [3:0] id,
                                              input logic [12:0] owner,
                                              input logic [31:0] delay);
      req_word_type w;
      w.op       = op;
      w.timer_id = id;
      w.owner_id = owner;
      w.delay    = delay;
      return w;
   endfunction

   function automatic req_word_type random_req();
      int          pick;
      logic [1:0]  op;
      logic [31:0] delay;
      pick = $urandom_range(99);
      if (pick < 60) delay = $urandom_range(6, 1);
      else if (pick < 85) delay = $urandom_range(40, 1);
      else delay = $urandom;
      pick = $urandom_range(99);
      if (pick < 40) begin
         op = OP_ADD;
      end else if (pick < 58) begin
         op = OP_DEL;
      end else if (pick < 95) begin
         op = OP_TICK;
      end else if (pick < 97) begin
         op = OP_ADD;
         delay = '0;
      end else begin
         op = OP_UNUSED;
      end
      return timer_req(op, 4'($urandom_range(15)), 13'($urandom_range(8191)), delay);
   endfunction

   task automatic send_word(input req_word_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
   endtask

   initial begin
      req_word_type w;
      int           sent;
      int           phase;
      int           i;
      logic [3:0]   offset;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_word(timer_req(OP_TICK, 4'd0, 13'd0, 32'd0));
      send_word(timer_req(OP_DEL, 4'd15, 13'd0, 32'd0));
      send_word(timer_req(OP_ADD, 4'd15, 13'h1FFF, 32'd0));
      send_word(timer_req(OP_ADD, 4'd0, 13'h1FFF, 32'hFFFF_FFFF));
      send_word(timer_req(OP_ADD, 4'd0, 13'd5, 32'd7));
      send_word(timer_req(OP_ADD, 4'd1, 13'd0, 32'd3));
      send_word(timer_req(OP_ADD, 4'd2, 13'd77, 32'd3));
      send_word(timer_req(OP_ADD, 4'd3, 13'd4096, 32'd1));
      send_word(timer_req(OP_DEL, 4'd1, 13'h1FFF, 32'hFFFF_FFFF));
      send_word(timer_req(OP_UNUSED, 4'd15, 13'h1FFF, 32'hFFFF_FFFF));
      send_word(timer_req(OP_TICK, 4'd15, 13'h1FFF, 32'hFFFF_FFFF));
      send_word(timer_req(OP_TICK, 4'd0, 13'd0, 32'd0));
      send_word(timer_req(OP_TICK, 4'd0, 13'd0, 32'd0));
      send_word(timer_req(OP_DEL, 4'd0, 13'd0, 32'd0));
      drain_results();

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct = 80;
               stall_pct = 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct = 80;
            end
            default: begin
               idle_pct = 28;
               stall_pct = 28;
            end
         endcase
         if (phase == 0) begin
            // fill every slot with the same deadline, one tick expires them all
            offset = 4'($urandom_range(15));
            for (i = 0; i < DLTQ_TIMER_SLOTS; i++)
               send_word(timer_req(OP_ADD, offset ^ i[3:0], 13'($urandom_range(8191)), 32'd1));
            send_word(timer_req(OP_TICK, 4'($urandom_range(15)), 13'($urandom_range(8191)),
                                $urandom));
            hold_go = 1'b1;
         end
         sent = 0;
         while (sent < PHASE_WORDS) begin
            w = random_req();
            send_word(w);
            if (w.op != OP_UNUSED) sent++;
         end
         drain_results();
      end

      repeat (100) @(posedge clock);
      if (fail_count == 0 && owed_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

`default_nettype wire
